@@ rtl/ptts_pkg.sv @@
`default_nettype none

package ptts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MASK_W    = 8;
    localparam int CNT_W     = 16;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_SUSPEND = 3'd1;
    localparam logic [2:0] OP_RESUME  = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [1:0] RUN_IDLE      = 2'd0;
    localparam logic [1:0] RUN_READY     = 2'd1;
    localparam logic [1:0] RUN_SUSPENDED = 2'd2;
    localparam logic [1:0] RUN_DELETED   = 2'd3;

    typedef struct packed {
        logic             en_create;
        logic             en_state;
        logic             en_countdown;
        logic [IDX_W-1:0] idx;
        logic [1:0]       run_state;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] countdown;
    } slot_wr_t;

    typedef struct packed {
        logic             created;
        logic [1:0]       run_state;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] countdown;
    } slot_rd_t;

    typedef struct packed {
        logic             active;
        logic             fire;
        logic [CNT_W-1:0] countdown;
    } slot_upd_t;

endpackage

`default_nettype wire

@@ rtl/ptts_slot_table.sv @@
`default_nettype none

module ptts_slot_table
    import ptts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire slot_wr_t         wr,
    input  wire logic [IDX_W-1:0] rd_idx,
    output slot_rd_t              rd
);

    logic [NUM_SLOTS-1:0] created_reg;
    logic [1:0]           state_reg     [NUM_SLOTS];
    logic [CNT_W-1:0]     period_reg    [NUM_SLOTS];
    logic [CNT_W-1:0]     countdown_reg [NUM_SLOTS];

    // control bits reset, payload only read once a slot is created
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            created_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                state_reg[i] <= RUN_IDLE;
            end
        end
        else
        begin
            if (wr.en_create)
            begin
                created_reg[wr.idx] <= 1'b1;
            end
            if (wr.en_create || wr.en_state)
            begin
                state_reg[wr.idx] <= wr.run_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en_create)
        begin
            period_reg[wr.idx] <= wr.period;
        end
        if (wr.en_create || wr.en_countdown)
        begin
            countdown_reg[wr.idx] <= wr.countdown;
        end
    end

    always_comb
    begin
        rd.created   = created_reg[rd_idx];
        rd.run_state = state_reg[rd_idx];
        rd.period    = period_reg[rd_idx];
        rd.countdown = countdown_reg[rd_idx];
    end

endmodule

`default_nettype wire

@@ rtl/ptts_count_unit.sv @@
`default_nettype none

module ptts_count_unit
    import ptts_pkg::*;
(
    input  wire slot_rd_t  slot,
    output slot_upd_t      upd
);

    logic             at_zero;
    logic [CNT_W-1:0] operand;

    // one decrementer: reload from period when expired, else count down
    always_comb
    begin
        at_zero       = (slot.countdown == '0);
        operand       = at_zero ? slot.period : slot.countdown;
        upd.active    = slot.created && (slot.run_state == RUN_READY);
        upd.fire      = upd.active && at_zero;
        upd.countdown = operand - CNT_W'(1);
    end

endmodule

`default_nettype wire

@@ rtl/periodic_task_tick_scheduler_core.sv @@
`default_nettype none

// periodic task tick scheduler
// command channel: an item (op, task_id, period, first_delay) transfers at a
// rising edge where start is high and busy is low. op selects create,
// suspend, resume, delete or tick; unused op codes and out-of-range slot
// indexes leave the state untouched.
// result channel: done pulses for one cycle with fire_mask and tick_count;
// exactly one result per item. the receiver cannot stall, so the result is
// simply presented for that single cycle.
// a create/suspend/resume/delete item passes through ST_CMD and its result
// is registered into done; a tick walks the slot table one slot per cycle
// through a single countdown unit in ST_WALK, and its result is registered
// after the last slot. busy is high until the result cycle, when a new item
// can already be taken.
// reset (rst_n low, asynchronous) clears all slots to not created, the tick
// counter to zero and drops busy and done.
module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        op,
    input  wire logic [2:0]        task_id,
    input  wire logic [CNT_W-1:0]  period,
    input  wire logic [7:0]        first_delay,
    output logic                   done,
    output logic [MASK_W-1:0]      fire_mask,
    output logic [CNT_W-1:0]       tick_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMD  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]  tick_reg, tick_next;
    logic              done_reg, done_next;
    logic [MASK_W-1:0] fire_mask_reg, fire_mask_next;
    logic [CNT_W-1:0]  tick_count_reg, tick_count_next;

    logic [2:0]        op_reg;
    logic [2:0]        id_reg;
    logic [CNT_W-1:0]  period_reg;
    logic [7:0]        delay_reg;

    logic              accept;
    logic              id_ok;
    logic              last_slot;
    slot_wr_t          wr;
    slot_rd_t          rd;
    slot_upd_t         upd;

    ptts_slot_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (idx_reg),
        .rd     (rd)
    );

    ptts_count_unit u_count (
        .slot (rd),
        .upd  (upd)
    );

    assign accept    = start && !busy;
    assign id_ok     = 32'(id_reg) < NUM_SLOTS;
    assign last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            id_reg     <= task_id;
            period_reg <= period;
            delay_reg  <= first_delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            mask_reg       <= '0;
            tick_reg       <= '0;
            done_reg       <= 1'b0;
            fire_mask_reg  <= '0;
            tick_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            mask_reg       <= mask_next;
            tick_reg       <= tick_next;
            done_reg       <= done_next;
            fire_mask_reg  <= fire_mask_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        tick_next       = tick_reg;
        done_next       = 1'b0;
        fire_mask_next  = fire_mask_reg;
        tick_count_next = tick_count_reg;

        wr              = '0;
        wr.idx          = IDX_W'(id_reg);
        wr.period       = (period_reg == '0) ? CNT_W'(1) : period_reg;
        wr.countdown    = CNT_W'(delay_reg);
        wr.run_state    = RUN_READY;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = '0;
                    mask_next = '0;
                    state_next = (op == OP_TICK) ? ST_WALK : ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (id_ok)
                begin
                    unique case (op_reg)
                        OP_CREATE:  wr.en_create = 1'b1;
                        OP_SUSPEND:
                        begin
                            wr.en_state  = 1'b1;
                            wr.run_state = RUN_SUSPENDED;
                        end
                        OP_RESUME:
                        begin
                            wr.en_state  = 1'b1;
                            wr.run_state = RUN_READY;
                        end
                        OP_DELETE:
                        begin
                            wr.en_state  = 1'b1;
                            wr.run_state = RUN_DELETED;
                        end
                        default: ;
                    endcase
                end
                done_next       = 1'b1;
                fire_mask_next  = '0;
                tick_count_next = tick_reg;
                state_next      = ST_IDLE;
            end
            ST_WALK:
            begin
                wr.idx          = idx_reg;
                wr.en_countdown = upd.active;
                wr.countdown    = upd.countdown;
                for (int i = 0; i < MASK_W; i++)
                begin
                    if (upd.fire && (32'(idx_reg) == i))
                    begin
                        mask_next[i] = 1'b1;
                    end
                end
                if (last_slot)
                begin
                    tick_next       = tick_reg + CNT_W'(1);
                    done_next       = 1'b1;
                    fire_mask_next  = mask_next;
                    tick_count_next = tick_next;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign fire_mask  = fire_mask_reg;
    assign tick_count = tick_count_reg;

endmodule

`default_nettype wire
